// ===== rtl/pgwalk_pkg.sv =====
package pgwalk_pkg;

  localparam int unsigned WORDS_PER_FRAME = 512;
  localparam int unsigned IDX_W = 9;

  localparam int unsigned L0_SHIFT = 39;
  localparam int unsigned L1_SHIFT = 30;
  localparam int unsigned L2_SHIFT = 21;
  localparam int unsigned L3_SHIFT = 12;

  localparam logic [11:0] PAGE_MASK = 12'hFFF;
  localparam logic [IDX_W-1:0] IDX_LAST = 9'h1FF;
  localparam logic [63:0] LINK_BITS = 64'h7;
  localparam logic [6:0] COUNT_MAX = 7'd127;

  localparam int unsigned ENTRY_PRESENT_BIT = 0;
  localparam int unsigned ENTRY_USER_BIT = 2;

  localparam logic [1:0] LEVEL_TOP = 2'd0;
  localparam logic [1:0] LEVEL_PARENT_OF_LEAF = 2'd2;
  localparam logic [1:0] LEVEL_LEAF = 2'd3;

  localparam logic REG_ROOT_FRAME = 1'b0;
  localparam logic REG_FIRST_FREE = 1'b1;

  typedef enum logic [1:0] {
    MODE_STORE = 2'd0,
    MODE_MAP   = 2'd1,
    MODE_XLATE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MISALIGNED  = 3'd1,
    ST_NO_FRAMES   = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_USER_DENIED = 3'd4,
    ST_OUTSIDE     = 3'd5
  } status_e;

  typedef struct packed {
    logic [5:0] root_frame;
    logic [6:0] first_free_frame;
  } cfg_t;

  function automatic logic [IDX_W-1:0] level_index(logic [47:0] va, logic [1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      2'd0: idx = IDX_W'(va >> L0_SHIFT);
      2'd1: idx = IDX_W'(va >> L1_SHIFT);
      2'd2: idx = IDX_W'(va >> L2_SHIFT);
      default: idx = IDX_W'(va >> L3_SHIFT);
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/pgwalk_if.sv =====
interface pgwalk_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [47:0] vaddr;
  logic [51:0] ppage;
  logic [63:0] leaf_flags;
  logic        user_access;
  logic [14:0] store_index;
  logic [63:0] store_data;

  modport source (
    output valid, mode, vaddr, ppage, leaf_flags, user_access, store_index,
           store_data,
    input  ready
  );
  modport sink (
    input  valid, mode, vaddr, ppage, leaf_flags, user_access, store_index,
           store_data,
    output ready
  );
endinterface

interface pgwalk_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] phys_out;

  modport source (output valid, status, phys_out, input ready);
  modport sink (input valid, status, phys_out, output ready);
endinterface

// ===== rtl/pgwalk_cfg.sv =====
module pgwalk_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pgwalk_pkg::cfg_t   cfg_o
);

  logic [5:0] root_frame_q;
  logic [6:0] first_free_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_frame_q <= 6'd0;
      first_free_q <= 7'd1;
    end else if (wr_en) begin
      if (paddr[2] == pgwalk_pkg::REG_ROOT_FRAME) begin
        root_frame_q <= pwdata[5:0];
      end else begin
        first_free_q <= pwdata[6:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == pgwalk_pkg::REG_ROOT_FRAME) begin
      prdata = {26'd0, root_frame_q};
    end else begin
      prdata = {25'd0, first_free_q};
    end
  end

  assign cfg_o.root_frame       = root_frame_q;
  assign cfg_o.first_free_frame = first_free_q;

endmodule

// ===== rtl/pgwalk_store.sv =====
module pgwalk_store #(
  parameter int unsigned STORE_FRAMES = 64
) (
  input  logic                                               clk_i,
  input  logic                                               we_i,
  input  logic [$clog2(STORE_FRAMES)+pgwalk_pkg::IDX_W-1:0]  waddr_i,
  input  logic [63:0]                                        wdata_i,
  input  logic                                               re_i,
  input  logic [$clog2(STORE_FRAMES)+pgwalk_pkg::IDX_W-1:0]  raddr_i,
  output logic [63:0]                                        rdata_o
);

  localparam int unsigned WORDS = STORE_FRAMES * pgwalk_pkg::WORDS_PER_FRAME;

  logic [63:0] mem [WORDS];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pgwalk_seq.sv =====
module pgwalk_seq #(
  parameter int unsigned STORE_FRAMES = 64
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  pgwalk_in_if.sink                                          in_i,
  pgwalk_out_if.source                                       out_o,
  input  pgwalk_pkg::cfg_t                                   cfg_i,
  output logic                                               mem_we_o,
  output logic [$clog2(STORE_FRAMES)+pgwalk_pkg::IDX_W-1:0]  mem_waddr_o,
  output logic [63:0]                                        mem_wdata_o,
  output logic                                               mem_re_o,
  output logic [$clog2(STORE_FRAMES)+pgwalk_pkg::IDX_W-1:0]  mem_raddr_o,
  input  logic [63:0]                                        mem_rdata_i
);

  localparam int unsigned WORDS = STORE_FRAMES * pgwalk_pkg::WORDS_PER_FRAME;
  localparam int unsigned FW = $clog2(STORE_FRAMES);
  localparam int unsigned AW = FW + pgwalk_pkg::IDX_W;
  localparam int unsigned IW = pgwalk_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_ZERO,
    S_LINK,
    S_LEAF
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  pgwalk_pkg::status_e status_q, status_d;
  logic [63:0]         phys_q, phys_d;
  logic [6:0]          count_q, count_d;

  pgwalk_pkg::mode_e   mode_q, mode_d;
  logic [47:0]         va_q, va_d;
  logic [51:0]         pa_q, pa_d;
  logic [63:0]         flags_q, flags_d;
  logic                user_q, user_d;
  logic [FW-1:0]       cur_q, cur_d;
  logic [FW-1:0]       nxt_q, nxt_d;
  logic [1:0]          level_q, level_d;
  logic [IW-1:0]       zcnt_q, zcnt_d;

  logic                in_ready;
  logic                accept;
  logic [IW-1:0]       rd_idx;
  logic [7:0]          alloc;
  logic                alloc_bad;
  logic                root_bad;
  logic                ent_out;
  logic                idx_ok;
  logic [63:0]         ent;

  assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
  assign in_i.ready = in_ready;
  assign accept    = in_i.valid && in_ready;

  assign ent       = mem_rdata_i;
  assign rd_idx    = pgwalk_pkg::level_index(va_q, level_q);
  assign alloc     = {1'b0, cfg_i.first_free_frame} + {1'b0, count_q};
  assign alloc_bad = (count_q == pgwalk_pkg::COUNT_MAX) || (32'(alloc) >= STORE_FRAMES);
  assign root_bad  = 32'(cfg_i.root_frame) >= STORE_FRAMES;
  assign ent_out   = ent[63:12] >= 52'(STORE_FRAMES);
  assign idx_ok    = 32'(in_i.store_index) < WORDS;

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = status_q;
  assign out_o.phys_out = phys_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    phys_d      = phys_q;
    count_d     = count_q;
    mode_d      = mode_q;
    va_d        = va_q;
    pa_d        = pa_q;
    flags_d     = flags_q;
    user_d      = user_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    level_d     = level_q;
    zcnt_d      = zcnt_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = {cur_q, rd_idx};
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = {cur_q, rd_idx};

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d  = pgwalk_pkg::mode_e'(in_i.mode);
          va_d    = in_i.vaddr;
          pa_d    = in_i.ppage;
          flags_d = in_i.leaf_flags;
          user_d  = in_i.user_access;
          cur_d   = FW'(cfg_i.root_frame);
          level_d = pgwalk_pkg::LEVEL_TOP;
          phys_d  = '0;
          status_d = pgwalk_pkg::ST_OK;
          case (pgwalk_pkg::mode_e'(in_i.mode))
            pgwalk_pkg::MODE_STORE: begin
              out_valid_d = 1'b1;
              if (idx_ok) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(in_i.store_index);
                mem_wdata_o = in_i.store_data;
              end else begin
                status_d = pgwalk_pkg::ST_OUTSIDE;
              end
            end
            pgwalk_pkg::MODE_MAP: begin
              if ((in_i.vaddr[11:0] & pgwalk_pkg::PAGE_MASK) != 12'd0 ||
                  (in_i.ppage[11:0] & pgwalk_pkg::PAGE_MASK) != 12'd0) begin
                out_valid_d = 1'b1;
                status_d    = pgwalk_pkg::ST_MISALIGNED;
              end else if (root_bad) begin
                out_valid_d = 1'b1;
                status_d    = pgwalk_pkg::ST_OUTSIDE;
              end else begin
                state_d = S_READ;
              end
            end
            pgwalk_pkg::MODE_XLATE: begin
              if (root_bad) begin
                out_valid_d = 1'b1;
                status_d    = pgwalk_pkg::ST_OUTSIDE;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        mem_re_o = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        if (mode_q == pgwalk_pkg::MODE_XLATE) begin
          if (!ent[pgwalk_pkg::ENTRY_PRESENT_BIT]) begin
            out_valid_d = 1'b1;
            status_d    = pgwalk_pkg::ST_NOT_PRESENT;
            state_d     = S_IDLE;
          end else if (level_q == pgwalk_pkg::LEVEL_LEAF) begin
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
            if (user_q && !ent[pgwalk_pkg::ENTRY_USER_BIT]) begin
              status_d = pgwalk_pkg::ST_USER_DENIED;
            end else begin
              phys_d = {ent[63:12], va_q[11:0] & pgwalk_pkg::PAGE_MASK};
            end
          end else if (ent_out) begin
            out_valid_d = 1'b1;
            status_d    = pgwalk_pkg::ST_OUTSIDE;
            state_d     = S_IDLE;
          end else begin
            cur_d   = FW'(ent[63:12]);
            level_d = level_q + 1'b1;
            state_d = S_READ;
          end
        end else begin
          if (ent[pgwalk_pkg::ENTRY_PRESENT_BIT]) begin
            if (ent_out) begin
              out_valid_d = 1'b1;
              status_d    = pgwalk_pkg::ST_OUTSIDE;
              state_d     = S_IDLE;
            end else begin
              cur_d   = FW'(ent[63:12]);
              level_d = level_q + 1'b1;
              state_d = (level_q == pgwalk_pkg::LEVEL_PARENT_OF_LEAF) ? S_LEAF : S_READ;
            end
          end else if (alloc_bad) begin
            out_valid_d = 1'b1;
            status_d    = pgwalk_pkg::ST_NO_FRAMES;
            state_d     = S_IDLE;
          end else begin
            count_d = count_q + 1'b1;
            nxt_d   = FW'(alloc);
            zcnt_d  = '0;
            state_d = S_ZERO;
          end
        end
      end
      S_ZERO: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = {nxt_q, zcnt_q};
        if (zcnt_q == pgwalk_pkg::IDX_LAST) begin
          state_d = S_LINK;
        end else begin
          zcnt_d = zcnt_q + 1'b1;
        end
      end
      S_LINK: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = 64'({nxt_q, 12'd0}) | pgwalk_pkg::LINK_BITS;
        cur_d       = nxt_q;
        level_d     = level_q + 1'b1;
        state_d     = (level_q == pgwalk_pkg::LEVEL_PARENT_OF_LEAF) ? S_LEAF : S_READ;
      end
      S_LEAF: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {12'd0, pa_q} | flags_q;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= pgwalk_pkg::ST_OK;
      phys_q      <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      phys_q      <= phys_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    va_q    <= va_d;
    pa_q    <= pa_d;
    flags_q <= flags_d;
    user_q  <= user_d;
    cur_q   <= cur_d;
    nxt_q   <= nxt_d;
    level_q <= level_d;
    zcnt_q  <= zcnt_d;
  end

endmodule

// ===== rtl/four_level_page_table_walker.sv =====
// Four-level page-table walker over an on-chip store of 512-word table frames.
// Items arrive on in_i and each gives exactly one result beat on out_o; both are
// valid/ready channels. Registers root_frame (address 0) and first_free_frame
// (address 4) are written over the APB port, by the user only while the walker
// is idle; the block itself does not enforce it. After reset the store is swept
// to zero at one word a cycle over all STORE_FRAMES*512 words; in_i is not
// ready until the sweep ends. One item is handled at a time through the store's
// write port and read port, with registered read data. A store write is made as
// the item is accepted. A translate reads and checks one entry per level. A map
// reads each existing level; each new table frame is zeroed word by word and
// then linked into its parent, and the leaf entry is written last.
// The result is held in an output register until it is taken; while it waits,
// in_i stays not ready, so a stalled receiver holds off the next beat.
module four_level_page_table_walker #(
  parameter int unsigned STORE_FRAMES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pgwalk_in_if.sink     in_i,
  pgwalk_out_if.source  out_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned AW = $clog2(STORE_FRAMES) + pgwalk_pkg::IDX_W;

  pgwalk_pkg::cfg_t cfg;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [63:0]      mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [63:0]      mem_rdata;

  pgwalk_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pgwalk_seq #(
    .STORE_FRAMES (STORE_FRAMES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_i       (cfg),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pgwalk_store #(
    .STORE_FRAMES (STORE_FRAMES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FRAME_COUNT = 64;
  localparam int unsigned STORE_WORDS = FRAME_COUNT * pgwalk_pkg::WORDS_PER_FRAME;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] vaddr;
    logic [51:0] ppage;
    logic [63:0] leaf_flags;
    logic        user_access;
    logic [14:0] store_index;
    logic [63:0] store_data;
  } walk_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] phys_out;
  } walk_rsp_t;

  typedef struct packed {
    walk_req_t req;
    logic      fixed;
    walk_rsp_t rsp;
  } directed_row_t;

  localparam directed_row_t DIRECTED [24] = '{
    {pgwalk_pkg::MODE_XLATE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_NOT_PRESENT, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0, 1'b1, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_NOT_PRESENT, 64'h0},
    {pgwalk_pkg::MODE_MAP, 48'h1234, 52'h5000, 64'h7, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_MISALIGNED, 64'h0},
    {pgwalk_pkg::MODE_MAP, 48'h5000, 52'h5001, 64'h7, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_MISALIGNED, 64'h0},
    {pgwalk_pkg::MODE_MAP, 48'h0, 52'hF_FFFF_FFFF_F000, 64'h7, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'hABC, 52'h0, 64'h0, 1'b1, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OK, 64'h000F_FFFF_FFFF_FABC},
    {pgwalk_pkg::MODE_MAP, 48'h1000, 52'h5000, 64'h1, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'h1FFF, 52'h0, 64'h0, 1'b1, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_USER_DENIED, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'h1FFF, 52'h0, 64'h0, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OK, 64'h5FFF},
    {pgwalk_pkg::MODE_MAP, 48'hFFFF_FFFF_F000, 52'h0, ALL_ONES, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0, 1'b1, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OK, ALL_ONES},
    {pgwalk_pkg::MODE_XLATE, 48'h3000, 52'h0, 64'h0, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_NOT_PRESENT, 64'h0},
    {pgwalk_pkg::MODE_STORE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h0, 64'h46001,
     1'b1, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OUTSIDE, 64'h0},
    {pgwalk_pkg::MODE_MAP, 48'h2000, 52'h3000, 64'h7, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OUTSIDE, 64'h0},
    {pgwalk_pkg::MODE_STORE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h0, 64'h1007,
     1'b1, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_STORE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h7FFF, ALL_ONES,
     1'b1, pgwalk_pkg::ST_OK, 64'h0},
    {MODE_UNUSED, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, ALL_ONES, 1'b1, 15'h7FFF,
     ALL_ONES, 1'b1, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_STORE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h200, 64'hFFFF_FFFF_FFFF_F001,
     1'b0, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_OUTSIDE, 64'h0},
    {pgwalk_pkg::MODE_STORE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h200, 64'h2007,
     1'b0, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'h1008, 52'h0, 64'h0, 1'b0, 15'h0, 64'h0,
     1'b0, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_STORE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h600, 64'h0,
     1'b0, pgwalk_pkg::ST_OK, 64'h0},
    {pgwalk_pkg::MODE_XLATE, 48'h0, 52'h0, 64'h0, 1'b0, 15'h0, 64'h0,
     1'b1, pgwalk_pkg::ST_NOT_PRESENT, 64'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pgwalk_in_if  in_if ();
  pgwalk_out_if out_if ();

  four_level_page_table_walker #(
    .STORE_FRAMES(FRAME_COUNT)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [63:0]      page_mem [STORE_WORDS];
  int unsigned      frames_given;
  pgwalk_pkg::cfg_t walk_cfg;
  walk_rsp_t        pending_results [$];
  logic [47:0]      mapped_pages [$];
  int unsigned      errors;
  int unsigned      results_seen;
  int unsigned      burst_left;
  bit               calm;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned table_slot(logic [63:0] frame, logic [47:0] va,
                                             int unsigned lv);
    logic [47:0] shifted;
    case (lv)
      0: shifted = va >> pgwalk_pkg::L0_SHIFT;
      1: shifted = va >> pgwalk_pkg::L1_SHIFT;
      2: shifted = va >> pgwalk_pkg::L2_SHIFT;
      default: shifted = va >> pgwalk_pkg::L3_SHIFT;
    endcase
    return frame[5:0] * pgwalk_pkg::WORDS_PER_FRAME + shifted[8:0];
  endfunction

  // Applies one item to the shadow tables and returns the result it must give.
  function automatic walk_rsp_t run_walk(walk_req_t r);
    walk_rsp_t   o;
    logic [63:0] cur;
    logic [63:0] nxt;
    logic [63:0] e;
    int unsigned slot;
    bit          stop;
    o.status = pgwalk_pkg::ST_OK;
    o.phys_out = '0;
    cur = 64'(walk_cfg.root_frame);
    stop = 1'b0;
    case (r.mode)
      pgwalk_pkg::MODE_STORE: begin
        if (r.store_index < STORE_WORDS) page_mem[r.store_index] = r.store_data;
        else o.status = pgwalk_pkg::ST_OUTSIDE;
      end
      pgwalk_pkg::MODE_MAP: begin
        if (r.vaddr[11:0] != '0 || r.ppage[11:0] != '0) begin
          o.status = pgwalk_pkg::ST_MISALIGNED;
        end else if (cur >= FRAME_COUNT) begin
          o.status = pgwalk_pkg::ST_OUTSIDE;
        end else begin
          for (int lv = 0; lv < 3 && !stop; lv++) begin
            slot = table_slot(cur, r.vaddr, lv);
            e = page_mem[slot];
            if (e[pgwalk_pkg::ENTRY_PRESENT_BIT]) begin
              nxt = e >> 12;
              if (nxt >= FRAME_COUNT) begin
                o.status = pgwalk_pkg::ST_OUTSIDE;
                stop = 1'b1;
              end
            end else begin
              nxt = 64'(walk_cfg.first_free_frame) + frames_given;
              if (frames_given >= pgwalk_pkg::COUNT_MAX || nxt >= FRAME_COUNT) begin
                o.status = pgwalk_pkg::ST_NO_FRAMES;
                stop = 1'b1;
              end else begin
                frames_given++;
                for (int w = 0; w < pgwalk_pkg::WORDS_PER_FRAME; w++) begin
                  page_mem[nxt[5:0] * pgwalk_pkg::WORDS_PER_FRAME + w] = '0;
                end
                page_mem[slot] = (nxt << 12) | pgwalk_pkg::LINK_BITS;
              end
            end
            cur = nxt;
          end
          if (!stop) begin
            page_mem[table_slot(cur, r.vaddr, 3)] = 64'(r.ppage) | r.leaf_flags;
          end
        end
      end
      pgwalk_pkg::MODE_XLATE: begin
        if (cur >= FRAME_COUNT) begin
          o.status = pgwalk_pkg::ST_OUTSIDE;
        end else begin
          for (int lv = 0; lv < 4 && !stop; lv++) begin
            e = page_mem[table_slot(cur, r.vaddr, lv)];
            if (!e[pgwalk_pkg::ENTRY_PRESENT_BIT]) begin
              o.status = pgwalk_pkg::ST_NOT_PRESENT;
              stop = 1'b1;
            end else if (lv == 3) begin
              if (r.user_access && !e[pgwalk_pkg::ENTRY_USER_BIT]) begin
                o.status = pgwalk_pkg::ST_USER_DENIED;
              end else begin
                o.phys_out = {e[63:12], r.vaddr[11:0]};
              end
            end else begin
              cur = e >> 12;
              if (cur >= FRAME_COUNT) begin
                o.status = pgwalk_pkg::ST_OUTSIDE;
                stop = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Page addresses drawn from a few table paths, so maps share tables and
  // translations find what was mapped.
  function automatic logic [47:0] pool_page();
    logic [8:0] i0;
    logic [8:0] i1;
    logic [8:0] i2;
    case ($urandom_range(3))
      0: i0 = 9'd0;
      1: i0 = 9'd1;
      2: i0 = 9'd255;
      default: i0 = pgwalk_pkg::IDX_LAST;
    endcase
    case ($urandom_range(2))
      0: i1 = 9'd0;
      1: i1 = 9'd3;
      default: i1 = pgwalk_pkg::IDX_LAST;
    endcase
    case ($urandom_range(2))
      0: i2 = 9'd0;
      1: i2 = 9'd7;
      default: i2 = pgwalk_pkg::IDX_LAST;
    endcase
    return {i0, i1, i2, 9'($urandom), 12'h0};
  endfunction

  function automatic walk_req_t random_item();
    walk_req_t   r;
    int unsigned pick;
    int unsigned top;
    r.mode = MODE_UNUSED;
    r.vaddr = 48'(rand64());
    r.ppage = 52'(rand64());
    r.leaf_flags = rand64();
    r.user_access = 1'($urandom);
    r.store_index = 15'($urandom);
    r.store_data = rand64();
    pick = $urandom_range(99);
    if (pick < 35) begin
      r.mode = pgwalk_pkg::MODE_MAP;
      if ($urandom_range(19) != 0) r.vaddr = pool_page();
      if ($urandom_range(19) != 0) r.ppage[11:0] = '0;
      if ($urandom_range(4) != 0) r.leaf_flags[pgwalk_pkg::ENTRY_PRESENT_BIT] = 1'b1;
    end else if (pick < 80) begin
      r.mode = pgwalk_pkg::MODE_XLATE;
      case ($urandom_range(9))
        0: ;
        1, 2: r.vaddr = pool_page() | 48'($urandom_range(4095));
        default: begin
          if (mapped_pages.size() != 0) begin
            r.vaddr = mapped_pages[$urandom_range(mapped_pages.size() - 1)]
                      | 48'($urandom_range(4095));
          end
        end
      endcase
    end else if (pick < 97) begin
      r.mode = pgwalk_pkg::MODE_STORE;
      if ($urandom_range(4) != 0) begin
        top = frames_given < 63 ? frames_given + 1 : 63;
        r.store_index = 15'(table_slot(64'($urandom_range(top)), pool_page(),
                                       $urandom_range(3)));
        case ($urandom_range(5))
          0: begin
            r.store_data[pgwalk_pkg::ENTRY_PRESENT_BIT] = 1'b1;
            r.store_data[18] = 1'b1;
          end
          1: r.store_data[pgwalk_pkg::ENTRY_PRESENT_BIT] = 1'b0;
          default: begin
            r.store_data = {46'h0, 6'($urandom_range(FRAME_COUNT - 1)),
                            r.store_data[11:1], 1'b1};
          end
        endcase
      end
    end
    return r;
  endfunction

  task automatic reg_write(logic sel, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == pgwalk_pkg::REG_ROOT_FRAME) walk_cfg.root_frame = value[5:0];
    else walk_cfg.first_free_frame = value[6:0];
    @(posedge clk_i);
  endtask

  task automatic send_item(walk_req_t r, logic fixed, walk_rsp_t want);
    walk_rsp_t got;
    if (!calm && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid <= 1'b1;
    in_if.mode <= r.mode;
    in_if.vaddr <= r.vaddr;
    in_if.ppage <= r.ppage;
    in_if.leaf_flags <= r.leaf_flags;
    in_if.user_access <= r.user_access;
    in_if.store_index <= r.store_index;
    in_if.store_data <= r.store_data;
    do @(posedge clk_i); while (!in_if.ready);
    got = run_walk(r);
    if (r.mode == pgwalk_pkg::MODE_MAP && got.status == pgwalk_pkg::ST_OK) begin
      mapped_pages.push_back(r.vaddr);
      if (mapped_pages.size() > 128) void'(mapped_pages.pop_front());
    end
    pending_results.push_back(fixed ? want : got);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [5:0] root, logic [6:0] first_free, int unsigned count,
                           bit quiet);
    wait_drained();
    reg_write(pgwalk_pkg::REG_ROOT_FRAME, {26'($urandom), root});
    reg_write(pgwalk_pkg::REG_FIRST_FREE, {25'($urandom), first_free});
    calm = quiet;
    repeat (count) send_item(random_item(), 1'b0, '0);
    in_if.valid <= 1'b0;
  endtask

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.mode <= pgwalk_pkg::MODE_STORE;
    in_if.vaddr <= '0;
    in_if.ppage <= '0;
    in_if.leaf_flags <= '0;
    in_if.user_access <= 1'b0;
    in_if.store_index <= '0;
    in_if.store_data <= '0;
    foreach (page_mem[i]) page_mem[i] = '0;
    frames_given = 0;
    walk_cfg.root_frame = '0;
    walk_cfg.first_free_frame = 7'd1;
    errors = 0;
    burst_left = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_write(pgwalk_pkg::REG_ROOT_FRAME, 32'h0);
    reg_write(pgwalk_pkg::REG_FIRST_FREE, 32'h1);
    foreach (DIRECTED[i]) send_item(DIRECTED[i].req, DIRECTED[i].fixed, DIRECTED[i].rsp);
    in_if.valid <= 1'b0;
    run_phase(6'd0, 7'd1, 600, 1'b0);
    run_phase(6'd63, 7'd127, 200, 1'b1);
    run_phase(6'd1, 7'd0, 300, 1'b0);
    run_phase(6'd0, 7'd64, 200, 1'b0);
    run_phase(6'($urandom), 7'($urandom_range(70)), 200, 1'b0);
    run_phase(6'd0, 7'd1, 180, 1'b0);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    walk_rsp_t   want;
    int unsigned tick;
    int unsigned hold_left;
    logic [7:0]  stall_mask;
    bit          held;
    tick = 0;
    hold_left = 0;
    stall_mask = '1;
    held = 1'b0;
    results_seen = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result beat with no item waiting: status %0d", out_if.status);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            errors++;
          end
          if (out_if.phys_out !== want.phys_out) begin
            $error("phys_out: expected %h, got %h", want.phys_out, out_if.phys_out);
            errors++;
          end
        end
      end
      tick++;
      if (tick % 64 == 0) stall_mask = $urandom | $urandom;
      if (hold_left > 0) begin
        hold_left--;
      end else if (results_seen == 300 && !held) begin
        held = 1'b1;
        hold_left = 600;
      end
      out_if.ready <= hold_left == 0 && (calm || stall_mask[tick % 8]);
    end
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
